// File: src/wsd_pkg.sv
package wsd_pkg;

	// Parse steps of the frame header and payload
	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXT_HI  = 3'd2,
		PH_EXT_LO  = 3'd3,
		PH_KEY     = 3'd4,
		PH_PAYLOAD = 3'd5
	} phase_t;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [1:0] KEY_LAST  = 2'd3;

	localparam logic [3:0] OP_CONT   = 4'd0;
	localparam logic [3:0] OP_TEXT   = 4'd1;
	localparam logic [3:0] OP_BINARY = 4'd2;
	localparam logic [3:0] OP_CLOSE  = 4'd8;
	localparam logic [3:0] OP_PING   = 4'd9;
	localparam logic [3:0] OP_PONG   = 4'd10;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_data;
		logic [3:0] frame_opcode;
		logic       is_close;
		logic       unknown_opcode;
		logic       last;
		logic       length_error;
	} res_t;

	function automatic logic op_unknown(input logic [3:0] op);
		logic unk;
		case (op) inside
			OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: unk = 1'b0;
			default: unk = 1'b1;
		endcase
		return unk;
	endfunction

endpackage

// File: src/wsd_in_reg.sv
module wsd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	logic take;

	// Accept whenever the held byte is empty or leaves this cycle
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= in_byte;
		end
	end
endmodule

// File: src/wsd_parser.sv
module wsd_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    byte_s1,
	output logic          res_valid,
	output wsd_pkg::res_t res
);
	import wsd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        mask_on_q, mask_on_d;
	logic [15:0] remaining_q, remaining_d;
	logic [31:0] mask_key_q, mask_key_d;
	logic [1:0]  byte_index_q, byte_index_d;
	logic        halted_q, halted_d;
	logic [1:0]  key_sel;
	logic [6:0]  len7;
	logic        done_hdr;
	logic        emit;
	logic        emit_data;
	logic        emit_lerr;
	logic [7:0]  data;

	assign len7    = byte_s1[6:0];
	assign key_sel = KEY_LAST - byte_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HDR0;
			opcode_q     <= '0;
			mask_on_q    <= 1'b0;
			remaining_q  <= '0;
			mask_key_q   <= '0;
			byte_index_q <= '0;
			halted_q     <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			opcode_q     <= opcode_d;
			mask_on_q    <= mask_on_d;
			remaining_q  <= remaining_d;
			mask_key_q   <= mask_key_d;
			byte_index_q <= byte_index_d;
			halted_q     <= halted_d;
		end
	end

	always_comb begin
		phase_d      = phase_q;
		opcode_d     = opcode_q;
		mask_on_d    = mask_on_q;
		remaining_d  = remaining_q;
		mask_key_d   = mask_key_q;
		byte_index_d = byte_index_q;
		halted_d     = halted_q;
		done_hdr     = 1'b0;
		emit         = 1'b0;
		emit_data    = 1'b0;
		emit_lerr    = 1'b0;
		data         = byte_s1;

		if (!halted_q) begin
			unique case (phase_q)
				PH_HDR1: begin
					mask_on_d = byte_s1[7];
					if (len7 == LEN_EXT64) begin
						halted_d  = 1'b1;
						phase_d   = PH_HDR0;
						emit      = 1'b1;
						emit_lerr = 1'b1;
					end else if (len7 == LEN_EXT16) begin
						phase_d = PH_EXT_HI;
					end else begin
						remaining_d = {9'd0, len7};
						if (byte_s1[7]) begin
							byte_index_d = '0;
							phase_d      = PH_KEY;
						end else begin
							done_hdr = 1'b1;
						end
					end
				end
				PH_EXT_HI: begin
					remaining_d = {byte_s1, 8'd0};
					phase_d     = PH_EXT_LO;
				end
				PH_EXT_LO: begin
					remaining_d = {remaining_q[15:8], byte_s1};
					if (mask_on_q) begin
						byte_index_d = '0;
						phase_d      = PH_KEY;
					end else begin
						done_hdr = 1'b1;
					end
				end
				PH_KEY: begin
					mask_key_d[{key_sel, 3'b000} +: 8] = byte_s1;
					if (byte_index_q == KEY_LAST) begin
						done_hdr = 1'b1;
					end else begin
						byte_index_d = byte_index_q + 2'd1;
					end
				end
				PH_PAYLOAD: begin
					if (mask_on_q) begin
						data = byte_s1 ^ mask_key_q[{key_sel, 3'b000} +: 8];
					end
					byte_index_d = byte_index_q + 2'd1;
					remaining_d  = remaining_q - 16'd1;
					emit         = 1'b1;
					emit_data    = 1'b1;
					if (remaining_d == '0) begin
						phase_d      = PH_HDR0;
						byte_index_d = '0;
					end
				end
				default: begin
					opcode_d = byte_s1[3:0];
					phase_d  = PH_HDR1;
				end
			endcase

			// Length known and any key read: empty frame ends here
			if (done_hdr) begin
				byte_index_d = '0;
				if (remaining_d == '0) begin
					phase_d = PH_HDR0;
					emit    = 1'b1;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
		end
	end

	assign res_valid          = step && emit;
	assign res.out_byte       = emit_data ? data : 8'd0;
	assign res.has_data       = emit_data;
	assign res.frame_opcode   = opcode_q;
	assign res.is_close       = (opcode_q == OP_CLOSE);
	assign res.unknown_opcode = op_unknown(opcode_q);
	assign res.last           = emit_lerr || !emit_data || (remaining_d == '0);
	assign res.length_error   = emit_lerr;
endmodule

// File: src/wsd_out_reg.sv
module wsd_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_valid,
	input  wsd_pkg::res_t res,
	output logic          can_load,
	output logic          out_valid,
	input  logic          out_stall,
	output wsd_pkg::res_t res_q
);
	import wsd_pkg::*;

	logic load;

	assign can_load = !out_valid || !out_stall;
	assign load     = res_valid && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (can_load) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end
endmodule

// File: src/websocket_frame_deframer.sv
// Receive-side WebSocket frame deframer. Feed the received stream one byte
// per transfer on in_byte; header bytes (opcode, mask bit and 7-bit length,
// optional 16-bit big-endian extended length, optional 4-byte mask key) give
// no result, and each payload byte comes out unmasked with the frame opcode,
// a close flag, an unknown-opcode flag and last on the final byte. A frame of
// zero length gives one result with has_data low and last high. Length code
// 127 gives one result with length_error high, after which every input byte
// is taken and dropped until reset. RSV and FIN bits are ignored. The block
// sustains one byte per clock while out_stall is low: a byte is held in the
// input register, is parsed by single-level logic into the result register
// and appears on out_* from there. The only throttle is out_stall, which,
// with a result held, stalls the result and input registers together.
module websocket_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_data,
	output logic [3:0] frame_opcode,
	output logic       is_close,
	output logic       unknown_opcode,
	output logic       last,
	output logic       length_error
);
	import wsd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       can_load;
	logic       advance;
	logic       res_valid;
	res_t       res;
	res_t       res_q;

	// Advance the held byte whenever the result register can take its result
	assign advance = valid_s1 && can_load;

	wsd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign out_byte       = res_q.out_byte;
	assign has_data       = res_q.has_data;
	assign frame_opcode   = res_q.frame_opcode;
	assign is_close       = res_q.is_close;
	assign unknown_opcode = res_q.unknown_opcode;
	assign last           = res_q.last;
	assign length_error   = res_q.length_error;
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

import wsd_pkg::*;

// Tracks the parse of the received stream and holds the results that are
// still owed by the block, oldest first.
class frame_scoreboard;
	phase_t      step;
	logic [3:0]  op;
	logic        masked;
	logic [15:0] bytes_left;
	logic [31:0] key;
	logic [1:0]  key_pos;
	logic        stopped;
	res_t        owed_res[$];
	int          mismatches;

	function new();
		step       = PH_HDR0;
		op         = '0;
		masked     = 1'b0;
		bytes_left = '0;
		key        = '0;
		key_pos    = '0;
		stopped    = 1'b0;
		mismatches = 0;
	endfunction

	function int pending();
		return owed_res.size();
	endfunction

	function res_t outcome(logic [7:0] data, logic has, logic fin, logic lerr);
		res_t r;
		r.out_byte       = has ? data : 8'h00;
		r.has_data       = has;
		r.frame_opcode   = op;
		r.is_close       = (op == OP_CLOSE);
		r.unknown_opcode = !(op inside {OP_CONT, OP_TEXT, OP_BINARY,
			OP_CLOSE, OP_PING, OP_PONG});
		r.last           = fin;
		r.length_error   = lerr;
		return r;
	endfunction

	// Length and key are known: start the payload, or close an empty frame.
	function void finish_header();
		key_pos = '0;
		if (bytes_left == 16'd0) begin
			step = PH_HDR0;
			owed_res.push_back(outcome(8'h00, 1'b0, 1'b1, 1'b0));
		end else begin
			step = PH_PAYLOAD;
		end
	endfunction

	function void length_known();
		if (masked) begin
			key_pos = '0;
			step    = PH_KEY;
		end else begin
			finish_header();
		end
	endfunction

	// Advance the parse by one accepted byte.
	function void note_byte(logic [7:0] b);
		logic [7:0] data;
		if (stopped)
			return;
		case (step)
			PH_HDR1: begin
				masked = b[7];
				if (b[6:0] == LEN_EXT64) begin
					stopped = 1'b1;
					step    = PH_HDR0;
					owed_res.push_back(outcome(8'h00, 1'b0, 1'b1, 1'b1));
				end else if (b[6:0] == LEN_EXT16) begin
					step = PH_EXT_HI;
				end else begin
					bytes_left = {9'd0, b[6:0]};
					length_known();
				end
			end
			PH_EXT_HI: begin
				bytes_left = {b, 8'h00};
				step       = PH_EXT_LO;
			end
			PH_EXT_LO: begin
				bytes_left[7:0] = b;
				length_known();
			end
			PH_KEY: begin
				key[8 * (3 - key_pos) +: 8] = b;
				if (key_pos == KEY_LAST)
					finish_header();
				else
					key_pos = key_pos + 2'd1;
			end
			PH_PAYLOAD: begin
				data       = masked ? (b ^ key[8 * (3 - key_pos) +: 8]) : b;
				key_pos    = key_pos + 2'd1;
				bytes_left = bytes_left - 16'd1;
				if (bytes_left == 16'd0) begin
					step    = PH_HDR0;
					key_pos = '0;
				end
				owed_res.push_back(outcome(data, 1'b1, bytes_left == 16'd0, 1'b0));
			end
			default: begin
				op   = b[3:0];
				step = PH_HDR1;
			end
		endcase
	endfunction

	function void check_result(res_t got);
		res_t want;
		logic bad;
		if (owed_res.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"%0t: unexpected result byte=%h has=%b op=%h close=%b",
					" unk=%b last=%b lerr=%b"},
					$time, got.out_byte, got.has_data, got.frame_opcode, got.is_close,
					got.unknown_opcode, got.last, got.length_error);
			return;
		end
		want = owed_res.pop_front();
		bad  = (got.out_byte !== want.out_byte) || (got.has_data !== want.has_data) ||
			(got.frame_opcode !== want.frame_opcode) || (got.is_close !== want.is_close) ||
			(got.unknown_opcode !== want.unknown_opcode) || (got.last !== want.last) ||
			(got.length_error !== want.length_error);
		if (bad) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display({"%0t: mismatch expected byte=%h has=%b op=%h close=%b",
					" unk=%b last=%b lerr=%b"},
					$time, want.out_byte, want.has_data, want.frame_opcode, want.is_close,
					want.unknown_opcode, want.last, want.length_error);
				$display({"%0t:          actual   byte=%h has=%b op=%h close=%b",
					" unk=%b last=%b lerr=%b"},
					$time, got.out_byte, got.has_data, got.frame_opcode, got.is_close,
					got.unknown_opcode, got.last, got.length_error);
			end
		end
	endfunction
endclass

module tb;

	localparam int RAND_ITEMS = 1200;  // random bytes to send
	localparam int IDLE_LIMIT = 1000;  // cycles with no transfer before giving up
	localparam int DRAIN      = 10;    // tail after the last result

	logic       clk            = 1'b0;
	logic       arst_n         = 1'b0;
	logic       in_valid       = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte        = 8'h00;
	logic       out_valid;
	logic       out_stall      = 1'b0;
	logic [7:0] out_byte;
	logic       has_data;
	logic [3:0] frame_opcode;
	logic       is_close;
	logic       unknown_opcode;
	logic       last;
	logic       length_error;

	frame_scoreboard sb = new();

	bit calm  = 1'b0;  // no idling on either side while set
	bit guard = 1'b0;  // keep random bytes from halting the parser or asking huge lengths
	int sent  = 0;
	int idle_cycles = 0;

	// Hand-picked stream: empty frame, unknown opcode with all-ones header,
	// masked close, extended length below 126, masked empty frame by extended length.
	logic [7:0] intro [28] = '{
		8'h81, 8'h00,
		8'hFF, 8'h01, 8'hFF,
		8'h88, 8'h82, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'hFF,
		8'h09, 8'h7E, 8'h00, 8'h03, 8'h00, 8'h80, 8'h7F,
		8'h0A, 8'hFE, 8'h00, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78
	};

	websocket_frame_deframer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.has_data      (has_data),
		.frame_opcode  (frame_opcode),
		.is_close      (is_close),
		.unknown_opcode(unknown_opcode),
		.last          (last),
		.length_error  (length_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		return calm ? 0 : $urandom_range(0, 3);
	endfunction

	// Offer one byte and hold it until the block takes the transfer.
	// Signals read right after the edge carry their values from before it.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (guard) begin
			if (sb.step == PH_HDR1 && b[6:0] == LEN_EXT64)
				b[0] = 1'b0;
			if (sb.step == PH_EXT_HI)
				b = b & 8'h01;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_byte(b);
		sent++;
	endtask

	task automatic send_frame(input logic [7:0] head, input logic masked, input int len,
		input logic wide, input logic [31:0] key);
		logic [15:0] n;
		n = len[15:0];
		send_byte(head);
		send_byte({masked, wide ? LEN_EXT16 : n[6:0]});
		if (wide) begin
			send_byte(n[15:8]);
			send_byte(n[7:0]);
		end
		if (masked)
			for (int i = 0; i < 4; i++)
				send_byte(key[31 - 8 * i -: 8]);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	// Drop valid and hold off until every owed result has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0) @(posedge clk);
	endtask

	// Feed filler bytes until the parser stands at a frame boundary.
	task automatic resync();
		while (sb.step != PH_HDR0)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic random_frame();
		int pick;
		int len;
		logic wide;
		pick = $urandom_range(0, 99);
		wide = 1'b0;
		if (pick < 5) begin
			len = 0;
		end else if (pick < 60) begin
			len = $urandom_range(1, 8);
		end else if (pick < 80) begin
			len = $urandom_range(9, 125);
		end else begin
			len  = $urandom_range(0, 400);
			wide = 1'b1;
		end
		send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), len, wide,
			$urandom);
	endtask

	// Receiver: draw a stall for each result, then take the next transfer.
	initial begin
		res_t got;
		int   gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got.out_byte       = out_byte;
			got.has_data       = has_data;
			got.frame_opcode   = frame_opcode;
			got.is_close       = is_close;
			got.unknown_opcode = unknown_opcode;
			got.last           = last;
			got.length_error   = length_error;
			sb.check_result(got);
		end
	end

	// Watchdog: count cycles in which neither channel moves a transfer.
	initial begin
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		bit paused;
		int burst;
		paused = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed stream, then the longest short frame and a masked frame whose
		// extended length uses both length bytes.
		foreach (intro[i])
			send_byte(intro[i]);
		send_frame(8'h02, 1'b0, 125, 1'b0, 32'h0);
		send_frame(8'h81, 1'b1, 260, 1'b1, $urandom);

		// Random part: mostly well-formed frames, some noise bursts that knock
		// the parser out of step, followed by filler until it is back in step.
		guard = 1'b1;
		sent  = 0;
		while (sent < RAND_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				calm = !calm;
			if ($urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 6);
				repeat (burst) send_byte(8'($urandom_range(0, 255)));
				resync();
			end else begin
				random_frame();
			end
			if (!paused && sent > RAND_ITEMS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
		resync();
		guard = 1'b0;
		calm  = 1'b0;

		// Length code 127 halts the block; drop everything after it.
		send_byte(8'($urandom_range(0, 255)));
		send_byte({1'($urandom_range(0, 1)), LEN_EXT64});
		repeat (20) send_byte(8'($urandom_range(0, 255)));
		in_valid <= 1'b0;

		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
